### sv/csvft_pkg.sv
// Package for the CSV field tokenizer: shared types, register indexes and reset values.
// Used by csvft_cfg, csvft_step and csv_field_tokenizer_unit; depends on nothing.
package csvft_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned FieldIdxW = 4;
  localparam int unsigned FprW      = 5;
  localparam int unsigned CfgIdxW   = 2;

  // Reset values of the configuration registers.
  localparam logic [ByteW-1:0] SeparatorReset = 8'd44;  // comma
  localparam logic [ByteW-1:0] QuoteReset     = 8'd34;  // double quote
  localparam logic [FprW-1:0]  FprReset       = 5'd9;

  // Largest field count that the index can express.
  localparam logic [FprW-1:0]  FprMax         = 5'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEPARATOR = 2'd0,
    CFG_QUOTE     = 2'd1,
    CFG_FIELDS    = 2'd2
  } csvft_cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_QUOTED = 2'd1,
    MODE_HELD   = 2'd2
  } csvft_mode_e;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } csvft_kind_e;

  // Active configuration as seen by the decision logic.
  typedef struct packed {
    logic [ByteW-1:0]     separator;
    logic [ByteW-1:0]     quote;
    logic [FieldIdxW-1:0] last_index;  // index of the final field in a record
  } csvft_cfg_t;

  // One result transaction.
  typedef struct packed {
    csvft_kind_e          kind;
    logic [ByteW-1:0]     data;
    logic [FieldIdxW-1:0] index;
    logic                 rec_end;
  } csvft_result_t;

  // Tokenizer state carried from one byte to the next.
  typedef struct packed {
    csvft_mode_e          mode;
    logic [FieldIdxW-1:0] field_cnt;
  } csvft_state_t;

endpackage

### sv/csvft_cfg.sv
// Configuration registers of the CSV field tokenizer.
// Depends on csvft_pkg; presents the active settings as a csvft_cfg_t.
module csvft_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [csvft_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [csvft_pkg::ByteW-1:0]      cfg_data_i,
  output csvft_pkg::csvft_cfg_t            cfg_o
);

  logic [csvft_pkg::ByteW-1:0] sep_q, sep_d;
  logic [csvft_pkg::ByteW-1:0] quote_q, quote_d;
  logic [csvft_pkg::FprW-1:0]  fpr_q, fpr_d;
  logic [csvft_pkg::FieldIdxW-1:0] last_index;

  always_comb begin
    sep_d   = sep_q;
    quote_d = quote_q;
    fpr_d   = fpr_q;
    if (cfg_we_i) begin
      case (csvft_pkg::csvft_cfg_idx_e'(cfg_index_i))
        csvft_pkg::CFG_SEPARATOR: sep_d   = cfg_data_i;
        csvft_pkg::CFG_QUOTE:     quote_d = cfg_data_i;
        csvft_pkg::CFG_FIELDS:    fpr_d   = cfg_data_i[csvft_pkg::FprW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= csvft_pkg::SeparatorReset;
      quote_q <= csvft_pkg::QuoteReset;
      fpr_q   <= csvft_pkg::FprReset;
    end else begin
      sep_q   <= sep_d;
      quote_q <= quote_d;
      fpr_q   <= fpr_d;
    end
  end

  // A count of zero behaves as one field, and counts above the maximum are clamped.
  always_comb begin
    if (fpr_q == '0) begin
      last_index = '0;
    end else if (fpr_q >= csvft_pkg::FprMax) begin
      last_index = '1;
    end else begin
      last_index = fpr_q[csvft_pkg::FieldIdxW-1:0] - 1'b1;
    end
  end

  assign cfg_o = '{separator: sep_q, quote: quote_q, last_index: last_index};

endmodule

### sv/csvft_step.sv
// Per-byte decision logic of the CSV field tokenizer: next state and optional result.
// Depends on csvft_pkg; purely combinational.
module csvft_step (
  input  csvft_pkg::csvft_cfg_t          cfg_i,
  input  csvft_pkg::csvft_state_t        state_i,
  input  logic [csvft_pkg::ByteW-1:0]    byte_i,
  output csvft_pkg::csvft_state_t        state_o,
  output logic                           has_result_o,
  output csvft_pkg::csvft_result_t       result_o
);

  logic is_quote;
  logic is_sep;
  logic emit_end;
  logic last_field;
  csvft_pkg::csvft_mode_e          next_mode;
  logic [csvft_pkg::FieldIdxW-1:0] next_cnt;

  assign is_quote   = (byte_i == cfg_i.quote);
  assign is_sep     = (byte_i == cfg_i.separator);
  assign last_field = (state_i.field_cnt >= cfg_i.last_index);

  // Next quote mode, and whether a result is produced and of which kind.
  always_comb begin
    next_mode    = csvft_pkg::MODE_PLAIN;
    has_result_o = 1'b1;
    emit_end     = 1'b0;
    case (state_i.mode)
      csvft_pkg::MODE_QUOTED: begin
        if (is_quote) begin
          next_mode    = csvft_pkg::MODE_HELD;
          has_result_o = 1'b0;
        end else begin
          next_mode = csvft_pkg::MODE_QUOTED;
        end
      end
      csvft_pkg::MODE_HELD: begin
        // Doubled quote gives a literal quote; otherwise quoted text has closed.
        if (is_quote) begin
          next_mode = csvft_pkg::MODE_QUOTED;
        end else begin
          emit_end = is_sep;
        end
      end
      default: begin
        if (is_quote) begin
          next_mode    = csvft_pkg::MODE_QUOTED;
          has_result_o = 1'b0;
        end else begin
          emit_end = is_sep;
        end
      end
    endcase
  end

  // Result fields and field counter update.
  always_comb begin
    result_o.index = state_i.field_cnt;
    next_cnt       = state_i.field_cnt;
    if (emit_end) begin
      result_o.kind    = csvft_pkg::KIND_END;
      result_o.data    = '0;
      result_o.rec_end = last_field;
      next_cnt         = last_field ? '0 : state_i.field_cnt + 1'b1;
    end else begin
      result_o.kind    = csvft_pkg::KIND_DATA;
      result_o.data    = byte_i;
      result_o.rec_end = 1'b0;
    end
  end

  assign state_o = '{mode: next_mode, field_cnt: next_cnt};

endmodule

### sv/csv_field_tokenizer_unit.sv
// Top level of the CSV field tokenizer: input register, decision step, result register.
// Depends on csvft_pkg, csvft_cfg and csvft_step.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+--------------------------------------
//  in       | input     | in_valid_i/in_stall_o | in_byte_i
//  out      | output    | out_valid_o/out_stall_i | out_kind_o, out_byte_o,
//           |           |                       | field_index_o, record_end_o
//  cfg      | input     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// A byte is loaded into the input register when it is accepted, and passes through the
// decision step into the result register when it advances; its result is offered there.
// One byte is accepted every cycle while the output is not stalled; the combinational
// decision step sets that rate.
// Reset clears both valid flags, puts the tokenizer in unquoted mode at field zero
// and loads the default separator, quote and field count.
// A stall on the output holds the result register; the input register still drains
// bytes that produce no result (opening and held quotes) while the output is stalled.
module csv_field_tokenizer_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [csvft_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [csvft_pkg::ByteW-1:0]          cfg_data_i,
  // Input byte stream.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [csvft_pkg::ByteW-1:0]          in_byte_i,
  // Result stream.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 out_kind_o,
  output logic [csvft_pkg::ByteW-1:0]          out_byte_o,
  output logic [csvft_pkg::FieldIdxW-1:0]      field_index_o,
  output logic                                 record_end_o
);

  csvft_pkg::csvft_cfg_t    cfg;
  csvft_pkg::csvft_state_t  state_q, state_d, step_state;
  csvft_pkg::csvft_result_t step_result;
  csvft_pkg::csvft_result_t res_q, res_d;
  logic                     step_has_result;

  logic                          in_valid_q, in_valid_d;
  logic [csvft_pkg::ByteW-1:0]   in_byte_q, in_byte_d;
  logic                          out_valid_q, out_valid_d;
  logic                          in_take;
  logic                          advance;

  csvft_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  csvft_step u_step (
    .cfg_i        (cfg),
    .state_i      (state_q),
    .byte_i       (in_byte_q),
    .state_o      (step_state),
    .has_result_o (step_has_result),
    .result_o     (step_result)
  );

  // The held byte moves on when its result has somewhere to go: the result register
  // is empty, is being taken this cycle, or the byte produces no result at all.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i || !step_has_result);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    if (in_take) begin
      in_valid_d = 1'b1;
      in_byte_d  = in_byte_i;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // Tokenizer state changes only as a byte passes through the decision step.
  always_comb begin
    state_d = state_q;
    if (advance) begin
      state_d = step_state;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (advance && step_has_result) begin
      out_valid_d = 1'b1;
      res_d       = step_result;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      state_q.mode      <= csvft_pkg::MODE_PLAIN;
      state_q.field_cnt <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    res_q     <= res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = res_q.kind;
  assign out_byte_o    = res_q.data;
  assign field_index_o = res_q.index;
  assign record_end_o  = res_q.rec_end;

  // A field end never carries a data byte.
  a_end_zero_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.kind == csvft_pkg::KIND_END) |-> (res_q.data == '0))
    else $error("field end carries a non-zero byte");

  // Record end is only ever flagged on a field end.
  a_rec_end_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.rec_end |-> (res_q.kind == csvft_pkg::KIND_END))
    else $error("record end flagged on a data byte");

  // Closing a record returns the field counter to zero.
  a_rec_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step_has_result && step_result.rec_end |=> (state_q.field_cnt == '0))
    else $error("field counter did not wrap at record end");

  // A stalled result is neither dropped nor overwritten.
  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(res_q))
    else $error("stalled result was lost or changed");

endmodule

### sim/csv_field_tokenizer_unit_tb.sv
// Self-checking testbench for csv_field_tokenizer_unit: directed and random byte streams
// under several register settings, checked against an in-bench tokenizer predictor.
// Depends on csvft_pkg and csv_field_tokenizer_unit.
module csv_field_tokenizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csvft_pkg::*;

  localparam logic [ByteW-1:0] NewlineByte = 8'h0A;
  localparam logic [ByteW-1:0] CommaByte   = 8'h2C;
  localparam logic [ByteW-1:0] DquoteByte  = 8'h22;

  // Clock, reset and every input of the block start at known values.
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [ByteW-1:0]     cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [ByteW-1:0]     in_byte_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic                 out_kind_o;
  logic [ByteW-1:0]     out_byte_o;
  logic [FieldIdxW-1:0] field_index_o;
  logic                 record_end_o;

  csv_field_tokenizer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_kind_o    (out_kind_o),
    .out_byte_o    (out_byte_o),
    .field_index_o (field_index_o),
    .record_end_o  (record_end_o)
  );

  // The predictor keeps its own copy of the registers and of the tokenizer state.
  // Both are updated at the clock edge at which the block itself takes them in.
  logic [ByteW-1:0]     sep_reg;
  logic [ByteW-1:0]     quote_reg;
  logic [FprW-1:0]      fpr_reg;
  csvft_mode_e          tok_mode;
  logic [FieldIdxW-1:0] tok_field;

  // Tokens that the block still owes us, oldest first.
  csvft_result_t        pending_tokens[$];

  int                   bytes_sent   = 0;
  int                   fail_count   = 0;
  int                   sender_gap_pct = 0;  // chance of an idle burst before a byte
  bit                   calm         = 1'b0;  // set for the final stretch: no idling at all

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Safety net: a run that hangs is a failed run.
  initial begin
    #2_000_000;
    $display("csv_field_tokenizer_unit: mismatch");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // A data byte carries the index of the field that it belongs to.
  task automatic push_data(input logic [ByteW-1:0] b);
    csvft_result_t r;
    r.kind    = KIND_DATA;
    r.data    = b;
    r.index   = tok_field;
    r.rec_end = 1'b0;
    pending_tokens.push_back(r);
  endtask

  // A field end closes the record when the counter has reached the last field. The
  // comparison uses ">=" so that a counter stranded beyond a freshly lowered field
  // count still closes the record and returns to zero. A count of zero acts as one
  // and anything above sixteen acts as sixteen.
  task automatic push_field_end();
    csvft_result_t r;
    int            span;
    bit            is_last;
    span = int'(fpr_reg);
    if (span == 0) span = 1;
    if (span > int'(FprMax)) span = int'(FprMax);
    is_last   = int'(tok_field) >= span - 1;
    r.kind    = KIND_END;
    r.data    = '0;
    r.index   = tok_field;
    r.rec_end = is_last;
    pending_tokens.push_back(r);
    tok_field = is_last ? '0 : tok_field + 1'b1;
  endtask

  // Works out the token, if any, that one accepted byte produces. The quote test comes
  // first in every mode, so a quote byte that is also the separator behaves as a quote.
  task automatic tokenize_byte(input logic [ByteW-1:0] b);
    case (tok_mode)
      MODE_QUOTED: begin
        if (b == quote_reg) begin
          tok_mode = MODE_HELD;
        end else begin
          push_data(b);
        end
      end
      MODE_HELD: begin
        if (b == quote_reg) begin
          // Doubled quote: one literal quote, still inside the quoted text.
          tok_mode = MODE_QUOTED;
          push_data(b);
        end else begin
          // The held quote was a closing one; this byte is judged as unquoted.
          tok_mode = MODE_PLAIN;
          if (b == sep_reg) push_field_end();
          else push_data(b);
        end
      end
      default: begin
        tok_mode = MODE_PLAIN;
        if (b == quote_reg) tok_mode = MODE_QUOTED;
        else if (b == sep_reg) push_field_end();
        else push_data(b);
      end
    endcase
  endtask

  // ------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------

  // A result transaction completes at an edge where valid is high and our stall is low.
  // Outputs are read in the active region of the edge, before any update of that edge.
  always @(posedge clk_i) begin
    csvft_result_t exp_tok;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected result: kind %0d byte 0x%02h index %0d record_end %0d",
               out_kind_o, out_byte_o, field_index_o, record_end_o);
        fail_count++;
      end else begin
        exp_tok = pending_tokens.pop_front();
        if (out_kind_o !== exp_tok.kind) begin
          $error("out_kind: expected %0d, got %0d", exp_tok.kind, out_kind_o);
          fail_count++;
        end
        if (out_byte_o !== exp_tok.data) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", exp_tok.data, out_byte_o);
          fail_count++;
        end
        if (field_index_o !== exp_tok.index) begin
          $error("field_index: expected %0d, got %0d", exp_tok.index, field_index_o);
          fail_count++;
        end
        if (record_end_o !== exp_tok.rec_end) begin
          $error("record_end: expected %0d, got %0d", exp_tok.rec_end, record_end_o);
          fail_count++;
        end
      end
    end
  end

  // Receiver back-pressure: random stall bursts between free-running stretches
  // of varying length. Once the run turns calm the output is never stalled again.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        repeat ($urandom_range(0, 40)) @(posedge clk_i);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Offers one byte and returns at the edge where the transaction is accepted. Valid is
  // only lowered for an idle burst, so back-to-back bytes keep it high throughout.
  task automatic send_byte(input logic [ByteW-1:0] b);
    if (!calm && $urandom_range(0, 99) < sender_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tokenize_byte(b);
    bytes_sent++;
  endtask

  // Stops sending and waits until every owed token has arrived. A trailing quote produces
  // no token, so the task keeps waiting after that to let it clear the two-stage pipeline.
  task automatic drain_tokens();
    in_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Only called while the block is idle. The trailing wait keeps write enable from being
  // lowered and raised within one time step when writes follow each other.
  task automatic write_reg(input csvft_cfg_idx_e idx, input logic [ByteW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      CFG_SEPARATOR: sep_reg   = value;
      CFG_QUOTE:     quote_reg = value;
      CFG_FIELDS:    fpr_reg   = value[FprW-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Any byte that is neither the separator nor the quote.
  function automatic logic [ByteW-1:0] plain_byte();
    logic [ByteW-1:0] b;
    b = ByteW'($urandom_range(0, 255));
    while (b == sep_reg || b == quote_reg) b = ByteW'($urandom_range(0, 255));
    return b;
  endfunction

  // Mostly well-formed fields with random content: plain fields, quoted fields holding
  // separators, newlines and doubled quotes, some with a broken close, and a little
  // noise weighted towards the two special bytes.
  task automatic send_field();
    int shape;
    int len;
    shape = $urandom_range(0, 19);
    if (shape < 10) begin
      len = $urandom_range(0, 6);
      repeat (len) send_byte(plain_byte());
      send_byte(sep_reg);
    end else if (shape < 17) begin
      send_byte(quote_reg);
      len = $urandom_range(0, 6);
      repeat (len) begin
        case ($urandom_range(0, 5))
          0: begin
            send_byte(quote_reg);
            send_byte(quote_reg);
          end
          1:       send_byte(sep_reg);
          2:       send_byte(NewlineByte);
          default: send_byte(plain_byte());
        endcase
      end
      send_byte(quote_reg);
      if ($urandom_range(0, 4) == 0) send_byte(plain_byte());
      else send_byte(sep_reg);
    end else begin
      len = $urandom_range(1, 4);
      repeat (len) begin
        case ($urandom_range(0, 3))
          0:       send_byte(sep_reg);
          1:       send_byte(quote_reg);
          default: send_byte(ByteW'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  // Brings the tokenizer back to unquoted mode so that a following step starts clean.
  task automatic leave_quotes();
    if (tok_mode == MODE_QUOTED) send_byte(quote_reg);
    if (tok_mode == MODE_HELD) send_byte(plain_byte());
  endtask

  // One setting: drain, program all three registers, then stream random fields.
  task automatic run_setting(input logic [ByteW-1:0] sep, input logic [ByteW-1:0] quote,
                             input logic [FprW-1:0] fields, input int count);
    int start;
    drain_tokens();
    write_reg(CFG_SEPARATOR, sep);
    write_reg(CFG_QUOTE, quote);
    write_reg(CFG_FIELDS, ByteW'(fields));
    case ($urandom_range(0, 3))
      0:       sender_gap_pct = 0;
      1:       sender_gap_pct = 5;
      2:       sender_gap_pct = 20;
      default: sender_gap_pct = 45;
    endcase
    start = bytes_sent;
    while (bytes_sent - start < count) send_field();
    leave_quotes();
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Default registers: extreme byte values, a newline as plain data, a separator inside
  // quotes, a doubled quote, a quote closed by the separator, an empty quoted field
  // closed by an ordinary byte, and eight field ends, one short of closing a nine-field record.
  task automatic test_quoting_rules();
    logic [ByteW-1:0] stream[$];
    stream = '{8'h00, 8'hFF, NewlineByte, CommaByte,
               DquoteByte, 8'h71, CommaByte, DquoteByte, DquoteByte, DquoteByte, CommaByte,
               DquoteByte, DquoteByte, 8'h62, CommaByte,
               CommaByte, CommaByte, CommaByte, CommaByte, CommaByte};
    sender_gap_pct = 30;
    foreach (stream[i]) send_byte(stream[i]);
  endtask

  // With the quote and the separator equal the byte always acts as a quote, so quoted
  // text never ends a field and doubled quotes come out as data.
  task automatic test_quote_equals_separator();
    run_setting(8'h27, 8'h27, 5'd4, 60);
  endtask

  // Field counts at and beyond both ends of the range, and a counter left stranded
  // beyond the last field when the count is lowered.
  task automatic test_field_count_limits();
    run_setting(CommaByte, DquoteByte, 5'd0, 40);
    run_setting(CommaByte, DquoteByte, 5'd1, 40);
    run_setting(8'h3B, 8'h27, 5'd31, 40);
    run_setting(CommaByte, DquoteByte, FprMax, 40);
    while (tok_field < 4'd10) send_byte(sep_reg);
    run_setting(CommaByte, DquoteByte, 5'd3, 40);
  endtask

  // Separator and quote at the extreme byte values, both ways round.
  task automatic test_extreme_bytes();
    run_setting(8'h00, 8'hFF, 5'd16, 40);
    run_setting(8'hFF, 8'h00, 5'd7, 40);
  endtask

  // Random registers. Part way through, the sender stops until every owed token has
  // come back, then carries on without touching the registers.
  task automatic test_random_stream();
    logic [ByteW-1:0] sep;
    logic [ByteW-1:0] quote;
    repeat (3) begin
      sep   = ByteW'($urandom_range(0, 255));
      quote = ($urandom_range(0, 7) == 0) ? sep : 8'($urandom_range(0, 255));
      run_setting(sep, quote, FprW'($urandom_range(0, 31)), 40);
      drain_tokens();
      repeat (12) send_field();
    end
  endtask

  // Back to the reset values with neither side idling.
  task automatic test_steady_stream();
    drain_tokens();
    calm = 1'b1;
    run_setting(SeparatorReset, QuoteReset, FprReset, 60);
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    int wait_cycles;
    sep_reg   = SeparatorReset;
    quote_reg = QuoteReset;
    fpr_reg   = FprReset;
    tok_mode  = MODE_PLAIN;
    tok_field = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_quoting_rules();
    test_quote_equals_separator();
    test_field_count_limits();
    test_extreme_bytes();
    test_random_stream();
    test_steady_stream();

    // Every byte is in. Wait for the owed tokens, bounded, then a little longer so that
    // any stray extra result would still be caught.
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (pending_tokens.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (8) @(posedge clk_i);

    if (pending_tokens.size() != 0) begin
      $error("%0d expected results never arrived", pending_tokens.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("csv_field_tokenizer_unit: match");
    end else begin
      $display("csv_field_tokenizer_unit: mismatch");
    end
    $finish;
  end

endmodule
